FILE: hw/rtl/sapt_pkg.sv
// Types, constants and coefficient tables shared by the sensor averaging block.
package sapt_pkg;

   parameter int CODE_W    = 10;
   parameter int TEMP_W    = 9;
   parameter int THRESH_W  = 9;
   parameter int CSR_AW    = 2;
   parameter int CSR_DW    = 32;
   parameter int TERM_W    = 2;
   parameter int COEF_W    = 19;
   parameter int R_W       = 18;
   parameter int PROD_W    = 29;
   parameter int RCP_W     = 30;

   parameter logic [TERM_W-1:0] TERM_LAST = 2'd3;
   parameter logic [CSR_AW-1:0] ADDR_THRESHOLD = 2'd0;
   parameter logic signed [THRESH_W-1:0] THRESHOLD_RESET = 9'sd105;

   parameter logic [R_W:0]          OFFSET     = 19'd4869;
   parameter logic signed [TEMP_W-1:0] TEMP_HIGH = 9'sd125;
   parameter logic signed [TEMP_W-1:0] TEMP_LOW  = -9'sd45;

   // Reciprocals ceil(2^shift / divisor), exact for the dividend widths used.
   parameter logic [RCP_W-1:0] POLY_RCP        = 30'd549755814;
   parameter int               POLY_SHIFT      = 39;
   parameter logic [RCP_W-1:0] POLY_LAST_RCP   = 30'd879609303;
   parameter int               POLY_LAST_SHIFT = 43;
   parameter logic [RCP_W-1:0] SCALE_RCP       = 30'd671089;
   parameter int               SCALE_SHIFT     = 26;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_DIV,
      ST_AVG_TAKE,
      ST_MUL,
      ST_POLY_LOAD,
      ST_POLY_DIV,
      ST_POLY_TAKE,
      ST_SCALE_LOAD,
      ST_SCALE_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_AVG,
      DIV_POLY,
      DIV_SCALE
   } div_sel_type;

   typedef struct packed {
      logic               accept;
      logic               div_load;
      div_sel_type        div_sel;
      logic               div_step;
      logic               take_avg;
      logic               take_poly;
      logic               mul;
      logic [TERM_W-1:0]  term;
      logic               emit;
   } cmd_type;

   typedef struct packed {
      logic timed_out;
      logic group_last;
      logic div_done;
      logic out_busy;
   } sts_type;

   function automatic logic [COEF_W-1:0] coef(input logic [TERM_W-1:0] term);
      logic [COEF_W-1:0] c;
      unique case (term)
         2'd0:    c = 19'd18439;
         2'd1:    c = 19'd80705;
         2'd2:    c = 19'd185010;
         default: c = 19'd328430;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/sapt_ifs.sv
// Valid/ready channel interfaces for sensor read words and reading words.
interface sapt_req_if;
   logic                          valid;
   logic                          ready;
   logic [sapt_pkg::CODE_W-1:0]   sensor_code;
   logic                          read_timed_out;

   modport source (output valid, sensor_code, read_timed_out, input ready);
   modport sink (input valid, sensor_code, read_timed_out, output ready);
endinterface

interface sapt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sapt_pkg::CODE_W-1:0]          raw_average;
   logic signed [sapt_pkg::TEMP_W-1:0]   temperature_c;
   logic                                 read_failed;
   logic                                 out_of_range;
   logic                                 overheat;
   logic                                 changed;

   modport source (output valid, raw_average, temperature_c, read_failed, out_of_range,
                   overheat, changed, input ready);
   modport sink (input valid, raw_average, temperature_c, read_failed, out_of_range,
                 overheat, changed, output ready);
endinterface

FILE: hw/rtl/sensor_average_poly_temperature.sv
// Top level: sensor read averaging with Horner polynomial temperature conversion.
// A word that does not close a group is taken back to back; a word that closes a group, or a
// timeout word, holds input ready low until its reading is in the output register. The
// reciprocal-multiply divide is used six times per reading, five on timeout.
// One word in flight; the output register lets the next word in while a reading waits.
// Reset (synchronous) clears group sum, previous reading, output valid; threshold -> 105.
module sensor_average_poly_temperature #(
   parameter int SAMPLES_PER_READING = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   sapt_req_if.sink                        req_ch,
   sapt_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sapt_pkg::CSR_AW-1:0]     paddr,
   input  logic [sapt_pkg::CSR_DW-1:0]     pwdata,
   output logic [sapt_pkg::CSR_DW-1:0]     prdata,
   output logic                            pready
);

   sapt_pkg::cmd_type                     cmd;
   sapt_pkg::sts_type                     sts;
   logic signed [sapt_pkg::THRESH_W-1:0]  threshold;

   sapt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   sapt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sapt_dp #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .sensor_code    (req_ch.sensor_code),
      .read_timed_out (req_ch.read_timed_out),
      .threshold      (threshold),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .raw_average    (rsp_ch.raw_average),
      .temperature_c  (rsp_ch.temperature_c),
      .read_failed    (rsp_ch.read_failed),
      .out_of_range   (rsp_ch.out_of_range),
      .overheat       (rsp_ch.overheat),
      .changed        (rsp_ch.changed)
   );

endmodule

FILE: hw/rtl/sapt_csr.sv
// APB register file holding the overheat threshold.
module sapt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sapt_pkg::CSR_AW-1:0]         paddr,
   input  logic [sapt_pkg::CSR_DW-1:0]         pwdata,
   output logic [sapt_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready,
   output logic signed [sapt_pkg::THRESH_W-1:0] threshold
);

   logic signed [sapt_pkg::THRESH_W-1:0] threshold_ff;
   logic                                 addr_hit;

   assign addr_hit = (paddr == sapt_pkg::ADDR_THRESHOLD);
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sapt_pkg::THRESHOLD_RESET;
      end else if (psel && penable && pwrite && addr_hit) begin
         threshold_ff <= pwdata[sapt_pkg::THRESH_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (addr_hit) begin
         prdata = {{(sapt_pkg::CSR_DW-sapt_pkg::THRESH_W){threshold_ff[sapt_pkg::THRESH_W-1]}},
                   threshold_ff};
      end
   end

   assign threshold = threshold_ff;

endmodule

FILE: hw/rtl/sapt_ctrl.sv
// Sequencer for averaging, Horner terms and the final scale divide.
module sapt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sapt_pkg::sts_type   sts,
   output sapt_pkg::cmd_type   cmd
);

   sapt_pkg::state_type              state_ff, state_in;
   logic [sapt_pkg::TERM_W-1:0]      term_ff, term_in;
   logic                             accept;

   assign accept = req_valid && (state_ff == sapt_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sapt_pkg::ST_IDLE;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      unique case (state_ff)
         sapt_pkg::ST_IDLE: begin
            if (accept) begin
               if (sts.timed_out) begin
                  term_in  = '0;
                  state_in = sapt_pkg::ST_MUL;
               end else if (sts.group_last) begin
                  state_in = sapt_pkg::ST_AVG_DIV;
               end
            end
         end
         sapt_pkg::ST_AVG_DIV: begin
            if (sts.div_done) state_in = sapt_pkg::ST_AVG_TAKE;
         end
         sapt_pkg::ST_AVG_TAKE: begin
            term_in  = '0;
            state_in = sapt_pkg::ST_MUL;
         end
         sapt_pkg::ST_MUL:       state_in = sapt_pkg::ST_POLY_LOAD;
         sapt_pkg::ST_POLY_LOAD: state_in = sapt_pkg::ST_POLY_DIV;
         sapt_pkg::ST_POLY_DIV: begin
            if (sts.div_done) state_in = sapt_pkg::ST_POLY_TAKE;
         end
         sapt_pkg::ST_POLY_TAKE: begin
            if (term_ff == sapt_pkg::TERM_LAST) begin
               state_in = sapt_pkg::ST_SCALE_LOAD;
            end else begin
               term_in  = term_ff + 1'b1;
               state_in = sapt_pkg::ST_MUL;
            end
         end
         sapt_pkg::ST_SCALE_LOAD: state_in = sapt_pkg::ST_SCALE_DIV;
         sapt_pkg::ST_SCALE_DIV: begin
            if (sts.div_done) state_in = sapt_pkg::ST_DONE;
         end
         sapt_pkg::ST_DONE: begin
            if (!sts.out_busy) state_in = sapt_pkg::ST_IDLE;
         end
         default: state_in = sapt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_sel = sapt_pkg::DIV_AVG;
      cmd.term    = term_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         sapt_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = accept;
            if (accept && !sts.timed_out && sts.group_last) begin
               cmd.div_load = 1'b1;
               cmd.div_sel  = sapt_pkg::DIV_AVG;
            end
         end
         sapt_pkg::ST_AVG_DIV:   cmd.div_step = 1'b1;
         sapt_pkg::ST_AVG_TAKE:  cmd.take_avg = 1'b1;
         sapt_pkg::ST_MUL:       cmd.mul = 1'b1;
         sapt_pkg::ST_POLY_LOAD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = sapt_pkg::DIV_POLY;
         end
         sapt_pkg::ST_POLY_DIV:  cmd.div_step = 1'b1;
         sapt_pkg::ST_POLY_TAKE: cmd.take_poly = 1'b1;
         sapt_pkg::ST_SCALE_LOAD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = sapt_pkg::DIV_SCALE;
         end
         sapt_pkg::ST_SCALE_DIV: cmd.div_step = 1'b1;
         sapt_pkg::ST_DONE:      cmd.emit = !sts.out_busy;
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/sapt_dp.sv
// Datapath: group sum, shared multiplier, reciprocal-multiply divider and output word.
module sapt_dp #(
   parameter int SAMPLES_PER_READING = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sapt_pkg::cmd_type                     cmd,
   output sapt_pkg::sts_type                     sts,
   input  logic [sapt_pkg::CODE_W-1:0]           sensor_code,
   input  logic                                  read_timed_out,
   input  logic signed [sapt_pkg::THRESH_W-1:0]  threshold,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [sapt_pkg::CODE_W-1:0]           raw_average,
   output logic signed [sapt_pkg::TEMP_W-1:0]    temperature_c,
   output logic                                  read_failed,
   output logic                                  out_of_range,
   output logic                                  overheat,
   output logic                                  changed
);

   localparam int SUM_W = sapt_pkg::CODE_W + $clog2(SAMPLES_PER_READING);
   localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
   localparam int R_W   = sapt_pkg::R_W;
   localparam int P_W   = sapt_pkg::PROD_W;
   localparam int T_W   = sapt_pkg::TEMP_W;
   localparam int RCP_W = sapt_pkg::RCP_W;
   localparam int RPROD_W = P_W + RCP_W;
   localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_READING);
   localparam longint AVG_RCP = ((longint'(1) << AVG_SHIFT) + longint'(SAMPLES_PER_READING)
                                 - 1) / longint'(SAMPLES_PER_READING);

   logic [CNT_W-1:0]             count_ff;
   logic [SUM_W-1:0]             sum_ff;
   logic [SUM_W-1:0]             sum_add;
   logic                         group_last;

   logic [sapt_pkg::CODE_W-1:0]  x_ff;
   logic [R_W-1:0]               r_ff;
   logic                         failed_ff;
   logic [P_W-1:0]               prod_ff;
   logic [sapt_pkg::COEF_W-1:0]  coef_diff;

   logic [P_W-1:0]               dvd_ff;
   logic [RCP_W-1:0]             rcp_ff;
   sapt_pkg::div_sel_type        dsel_ff;
   logic                         last_ff;
   logic                         div_done_ff;
   logic [P_W-1:0]               quo_ff;
   logic                         neg_ff;
   logic [RPROD_W-1:0]           rprod;
   logic [P_W-1:0]               quo_next;

   logic signed [R_W:0]          offset_val;
   logic [R_W:0]                 offset_mag;
   logic [P_W-1:0]               dvd_sel;
   logic [RCP_W-1:0]             rcp_sel;

   logic [T_W-1:0]               quo_temp;
   logic signed [T_W-1:0]        temp_c;
   logic signed [T_W:0]          temp_diff;
   logic signed [T_W-1:0]        prev_ff;

   logic                         rsp_valid_ff;
   logic [sapt_pkg::CODE_W-1:0]  raw_ff;
   logic signed [T_W-1:0]        temp_ff;
   logic                         failed_out_ff;
   logic                         range_ff;
   logic                         overheat_ff;
   logic                         changed_ff;

   assign sum_add    = sum_ff + SUM_W'(sensor_code);
   assign group_last = (count_ff == CNT_W'(SAMPLES_PER_READING - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.accept) begin
         if (read_timed_out || group_last) begin
            count_ff <= '0;
            sum_ff   <= '0;
         end else begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_add;
         end
      end
   end

   assign coef_diff = sapt_pkg::coef(cmd.term) - sapt_pkg::COEF_W'(r_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept && read_timed_out) begin
         x_ff      <= '0;
         r_ff      <= '0;
         failed_ff <= 1'b1;
      end else if (cmd.take_avg) begin
         x_ff      <= quo_ff[sapt_pkg::CODE_W-1:0];
         r_ff      <= '0;
         failed_ff <= 1'b0;
      end else if (cmd.take_poly) begin
         r_ff <= quo_ff[R_W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= P_W'(coef_diff) * P_W'(x_ff);
      end
   end

   assign offset_val = $signed({1'b0, r_ff}) - $signed(sapt_pkg::OFFSET);
   assign offset_mag = offset_val[R_W] ? (~offset_val + 1'b1) : offset_val;

   always_comb begin
      case (cmd.div_sel)
         sapt_pkg::DIV_AVG: begin
            dvd_sel = P_W'(sum_add);
            rcp_sel = RCP_W'(AVG_RCP);
         end
         sapt_pkg::DIV_POLY: begin
            dvd_sel = prod_ff;
            rcp_sel = (cmd.term == sapt_pkg::TERM_LAST) ? sapt_pkg::POLY_LAST_RCP
                                                         : sapt_pkg::POLY_RCP;
         end
         sapt_pkg::DIV_SCALE: begin
            dvd_sel = P_W'(offset_mag);
            rcp_sel = sapt_pkg::SCALE_RCP;
         end
         default: begin
            dvd_sel = prod_ff;
            rcp_sel = sapt_pkg::POLY_RCP;
         end
      endcase
   end

   // Quotient is the high part of dividend times reciprocal.
   assign rprod = RPROD_W'(dvd_ff) * RPROD_W'(rcp_ff);

   always_comb begin
      case (dsel_ff)
         sapt_pkg::DIV_AVG:   quo_next = P_W'(rprod >> AVG_SHIFT);
         sapt_pkg::DIV_POLY: begin
            quo_next = last_ff ? P_W'(rprod >> sapt_pkg::POLY_LAST_SHIFT)
                               : P_W'(rprod >> sapt_pkg::POLY_SHIFT);
         end
         sapt_pkg::DIV_SCALE: quo_next = P_W'(rprod >> sapt_pkg::SCALE_SHIFT);
         default:             quo_next = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvd_ff      <= dvd_sel;
         rcp_ff      <= rcp_sel;
         dsel_ff     <= cmd.div_sel;
         last_ff     <= (cmd.term == sapt_pkg::TERM_LAST);
         div_done_ff <= 1'b0;
         if (cmd.div_sel == sapt_pkg::DIV_SCALE) begin
            neg_ff <= offset_val[R_W];
         end
      end else if (cmd.div_step) begin
         quo_ff      <= quo_next;
         div_done_ff <= 1'b1;
      end
   end

   assign quo_temp  = quo_ff[T_W-1:0];
   assign temp_c    = neg_ff ? $signed(~quo_temp + 1'b1) : $signed(quo_temp);
   assign temp_diff = {temp_c[T_W-1], temp_c} - {prev_ff[T_W-1], prev_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
         prev_ff      <= temp_c;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         raw_ff        <= x_ff;
         temp_ff       <= temp_c;
         failed_out_ff <= failed_ff;
         range_ff      <= (temp_c > sapt_pkg::TEMP_HIGH) || (temp_c < sapt_pkg::TEMP_LOW);
         overheat_ff   <= (temp_c > threshold);
         changed_ff    <= (temp_diff > 10'sd1) || (temp_diff < -10'sd1);
      end
   end

   assign sts.timed_out  = read_timed_out;
   assign sts.group_last = group_last;
   assign sts.div_done   = div_done_ff;
   assign sts.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign raw_average   = raw_ff;
   assign temperature_c = temp_ff;
   assign read_failed   = failed_out_ff;
   assign out_of_range  = range_ff;
   assign overheat      = overheat_ff;
   assign changed       = changed_ff;

endmodule

FILE: sim/sapt_reading_checker.sv
// Predicts sensor readings from observed words and compares them with the block's output.
module sapt_reading_checker #(
   parameter int SAMPLES_PER_READING = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   sapt_req_if                                    req_ch,
   sapt_rsp_if                                    rsp_ch,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic                                   pready,
   input  logic [sapt_pkg::CSR_AW-1:0]            paddr,
   input  logic [sapt_pkg::CSR_DW-1:0]            pwdata,
   output int                                     mismatches,
   output int                                     pending
);

   localparam int THRESHOLD_AT_RESET = 105;

   typedef struct {
      logic [sapt_pkg::CODE_W-1:0]         raw_average;
      logic signed [sapt_pkg::TEMP_W-1:0]  temperature_c;
      logic                                read_failed;
      logic                                out_of_range;
      logic                                overheat;
      logic                                changed;
   } reading_type;

   reading_type readings_due[$];
   int          fault_count = 0;
   int          reads_in_group;
   int          group_code_sum;
   int          last_celsius;
   int          overheat_limit;

   assign mismatches = fault_count;

   // Fourth-order Horner conversion, each divide truncating toward zero.
   function automatic int celsius_from_code(input int code);
      longint x;
      longint acc;
      x = code;
      acc = (18439 * x) / 1000;
      acc = ((80705 - acc) * x) / 1000;
      acc = ((185010 - acc) * x) / 1000;
      acc = ((328430 - acc) * x) / 10000;
      return int'((acc - 4869) / 100);
   endfunction

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   task automatic predict_word(input logic [sapt_pkg::CODE_W-1:0] code, input logic timed_out);
      reading_type r;
      int          avg;
      int          deg;
      int          delta;
      bit          emits;
      emits = 1'b0;
      avg = 0;
      if (timed_out) begin
         emits = 1'b1;
         reads_in_group = 0;
         group_code_sum = 0;
      end else begin
         group_code_sum += int'(code);
         reads_in_group++;
         if (reads_in_group >= SAMPLES_PER_READING) begin
            emits = 1'b1;
            avg = group_code_sum / SAMPLES_PER_READING;
            reads_in_group = 0;
            group_code_sum = 0;
         end
      end
      if (emits) begin
         deg = celsius_from_code(avg);
         delta = deg - last_celsius;
         r.raw_average   = avg[sapt_pkg::CODE_W-1:0];
         r.temperature_c = deg[sapt_pkg::TEMP_W-1:0];
         r.read_failed   = timed_out;
         r.out_of_range  = (deg > 125) || (deg < -45);
         r.overheat      = deg > overheat_limit;
         r.changed       = (delta > 1) || (delta < -1);
         readings_due.push_back(r);
         last_celsius = deg;
      end
   endtask

   task automatic check_reading();
      reading_type r;
      if (readings_due.size() == 0) begin
         $error("reading word with no expected reading: raw_average %0d temperature_c %0d",
                rsp_ch.raw_average, rsp_ch.temperature_c);
         fault_count++;
      end else begin
         r = readings_due.pop_front();
         compare_field("raw_average", r.raw_average, rsp_ch.raw_average);
         compare_field("temperature_c", r.temperature_c, rsp_ch.temperature_c);
         compare_field("read_failed", r.read_failed, rsp_ch.read_failed);
         compare_field("out_of_range", r.out_of_range, rsp_ch.out_of_range);
         compare_field("overheat", r.overheat, rsp_ch.overheat);
         compare_field("changed", r.changed, rsp_ch.changed);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         readings_due.delete();
         reads_in_group = 0;
         group_code_sum = 0;
         last_celsius = 0;
         overheat_limit = THRESHOLD_AT_RESET;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_reading();
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_word(req_ch.sensor_code, req_ch.read_timed_out);
         end
         if (psel && penable && pwrite && pready && paddr == sapt_pkg::ADDR_THRESHOLD) begin
            overheat_limit = int'($signed(pwdata[sapt_pkg::THRESH_W-1:0]));
         end
      end
      pending <= readings_due.size();
   end

endmodule

FILE: sim/sensor_average_poly_temperature_test.sv
// Testbench top: drives sensor read words and threshold writes, and reports the verdict.
module sensor_average_poly_temperature_test;

   localparam int GROUP_SIZE    = 4;
   localparam int SETTLE_CYCLES = 220;
   localparam int HOLD_CYCLES   = 1500;
   localparam int PHASE_WORDS   = 136;
   localparam int RUN_LIMIT     = 1000000;

   logic                          clock;
   logic                          reset;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [sapt_pkg::CSR_AW-1:0]   paddr;
   logic [sapt_pkg::CSR_DW-1:0]   pwdata;
   logic [sapt_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;
   int                            mismatches;
   int                            pending;
   int                            words_sent = 0;
   int unsigned                   cycle_count = 0;
   bit                            steady;
   bit                            hold_off_request;

   sapt_req_if req_ch ();
   sapt_rsp_if rsp_ch ();

   sensor_average_poly_temperature #(
      .SAMPLES_PER_READING(GROUP_SIZE)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sapt_reading_checker #(
      .SAMPLES_PER_READING(GROUP_SIZE)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Reading sink: random stalls, one long hold-off to back the block up.
   initial begin
      int  stall_left;
      bit  held;
      stall_left = 0;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !held) begin
            held = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   task automatic send_word(input logic [sapt_pkg::CODE_W-1:0] code, input logic timed_out);
      if (!steady && $urandom_range(99) < 6) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.sensor_code    <= code;
      req_ch.read_timed_out <= timed_out;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      steady <= (words_sent >= 300) && (words_sent < 450);
      hold_off_request <= words_sent >= 120;
   endtask

   // Drops valid and waits for the block to drain before a register write or the end.
   task automatic settle();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [sapt_pkg::THRESH_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= sapt_pkg::ADDR_THRESHOLD;
      pwdata  <= {{(sapt_pkg::CSR_DW-sapt_pkg::THRESH_W){value[sapt_pkg::THRESH_W-1]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Groups of codes around a drifting level, some noisy groups, and stray timeouts.
   task automatic send_random_words(input int count);
      int   level;
      int   v;
      int   pos;
      int   n;
      bit   noisy;
      logic timed_out;
      level = $urandom_range(1023);
      pos = 0;
      noisy = 1'b0;
      for (n = 0; n < count; n++) begin
         if (pos == 0) begin
            noisy = $urandom_range(99) < 25;
            if ($urandom_range(19) == 0) level = $urandom_range(1023);
            else level += int'($urandom_range(6)) - 3;
            if (level < 0) level = 0;
            if (level > 1023) level = 1023;
         end
         timed_out = $urandom_range(99) < 4;
         if (noisy || timed_out) begin
            v = $urandom_range(1023);
         end else begin
            v = level + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
         end
         send_word(v[sapt_pkg::CODE_W-1:0], timed_out);
         pos = timed_out ? 0 : (pos + 1) % GROUP_SIZE;
      end
   endtask

   initial begin
      logic signed [sapt_pkg::THRESH_W-1:0] limits[5];
      int                                   k;
      reset                 <= 1'b1;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.sensor_code    <= '0;
      req_ch.read_timed_out <= 1'b0;
      steady                <= 1'b0;
      hold_off_request      <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset threshold
      repeat (4) send_word(10'd0, 1'b0);
      repeat (4) send_word(10'd1023, 1'b0);
      send_word(10'd1, 1'b0);
      send_word(10'd2, 1'b0);
      send_word(10'd3, 1'b0);
      send_word(10'd5, 1'b0);
      send_word(10'd300, 1'b0);
      send_word(10'd500, 1'b0);
      send_word(10'd1023, 1'b1);
      send_word(10'd0, 1'b1);
      for (k = 0; k < 4; k++) send_word(10'(512 + k), 1'b0);
      for (k = 0; k < 4; k++) send_word(k[0] ? 10'h155 : 10'h2AA, 1'b0);

      limits[0] = -9'sd128;
      limits[1] = 9'sd255;
      limits[2] = 9'sd0;
      limits[3] = sapt_pkg::THRESH_W'(int'($urandom_range(207)) - 48);
      limits[4] = sapt_pkg::THRESH_W'(int'($urandom_range(383)) - 128);
      for (k = 0; k < 5; k++) begin
         settle();
         write_threshold(limits[k]);
         send_random_words(PHASE_WORDS);
      end

      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/sapt_pkg.sv
hw/rtl/sapt_ifs.sv
hw/rtl/sapt_csr.sv
hw/rtl/sapt_ctrl.sv
hw/rtl/sapt_dp.sv
hw/rtl/sensor_average_poly_temperature.sv
sim/sapt_reading_checker.sv
sim/sensor_average_poly_temperature_test.sv
